/* src/tsfq_pkg.sv */
package tsfq_pkg;

    // Storage sizing
    localparam int MAX_DEPTH = 64;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int FILL_W    = $clog2(MAX_DEPTH + 1);

    // Field widths
    localparam int DATA_W   = 32;
    localparam int CAP_W    = 7;
    localparam int CNT_W    = 8;
    localparam int STATUS_W = 2;

    // Compare and sum widths for capacity clamp and count saturation
    localparam int CMP_W = (CAP_W > FILL_W) ? CAP_W : FILL_W;
    localparam int SUM_W = ((FILL_W + 1) > CNT_W) ? (FILL_W + 1) : CNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
    localparam logic [CNT_W-1:0] CNT_SAT   = {CNT_W{1'b1}};

    // Command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_XFER,
        S_XFER_FIN,
        S_RESULT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic    enq_push;
        logic    res_load;
        t_status res_status;
        logic    pop_issue;
        logic    pop_capture;
        logic    xfer_clr;
        logic    xfer_rd;
        logic    xfer_fin;
        logic    out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic in_empty;
        logic out_empty;
        logic xfer_last;
        logic out_free;
    } t_dp_status;

endpackage

/* src/tsfq_ram.sv */
module tsfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold when not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tsfq_ctrl.sv */
module tsfq_ctrl
    import tsfq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_cmd,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_cmd == CMD_ENQ) begin
                        n_state = S_RESULT;
                    end else if (i_status.in_empty && i_status.out_empty) begin
                        n_state = S_RESULT;
                    end else if (!i_status.out_empty) begin
                        n_state = S_POP;
                    end else begin
                        n_state = S_XFER;
                    end
                end
            end
            S_POP:      n_state = S_RESULT;
            S_XFER: begin
                if (i_status.xfer_last) begin
                    n_state = S_XFER_FIN;
                end
            end
            S_XFER_FIN: n_state = S_RESULT;
            S_RESULT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_cmd == CMD_ENQ) begin
                        o_cmd.res_load = 1'b1;
                        if (i_status.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.enq_push = 1'b1;
                        end
                    end else if (i_status.in_empty && i_status.out_empty) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_EMPTY;
                    end else if (!i_status.out_empty) begin
                        o_cmd.pop_issue = 1'b1;
                    end else begin
                        o_cmd.xfer_clr = 1'b1;
                    end
                end
            end
            S_POP:      o_cmd.pop_capture = 1'b1;
            S_XFER:     o_cmd.xfer_rd = 1'b1;
            S_XFER_FIN: o_cmd.xfer_fin = 1'b1;
            S_RESULT:   o_cmd.out_load = i_status.out_free;
            default:    o_cmd = '0;
        endcase
    end

endmodule

/* src/tsfq_dp.sv */
module tsfq_dp
    import tsfq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wen,
    input  logic [CAP_W-1:0]    i_cfg_wdata,
    input  logic [DATA_W-1:0]   i_data_in,
    input  t_dp_cmd             i_cmd,
    input  logic                i_out_ready,
    output t_dp_status          o_status,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_out_status,
    output logic [DATA_W-1:0]   o_out_data,
    output logic [CNT_W-1:0]    o_out_count
);

    logic [CAP_W-1:0]    r_capacity;
    logic [FILL_W-1:0]   r_in_fill;
    logic [FILL_W-1:0]   r_out_fill;
    logic [FILL_W-1:0]   r_xfer_cnt;
    t_status             r_res_status;
    logic [DATA_W-1:0]   r_res_data;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   r_out_data;
    logic [CNT_W-1:0]    r_out_count;

    logic [CMP_W-1:0]    w_cap_ext;
    logic [CMP_W-1:0]    w_eff_cap;
    logic [FILL_W-1:0]   w_in_top;
    logic [FILL_W-1:0]   w_out_top;
    logic [FILL_W-1:0]   w_in_rd_idx;
    logic [FILL_W-1:0]   w_out_wr_idx;
    logic [SUM_W-1:0]    w_sum;
    logic [CNT_W-1:0]    w_count;
    logic                w_in_re;
    logic                w_out_we;
    logic [DATA_W-1:0]   w_in_rdata;
    logic [DATA_W-1:0]   w_out_rdata;

    // Clamp capacity into one through the stack depth
    always_comb begin
        w_cap_ext = CMP_W'(r_capacity);
        if (w_cap_ext == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(MAX_DEPTH)) begin
            w_eff_cap = CMP_W'(MAX_DEPTH);
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end

    // Stack pointers and addresses
    assign w_in_top     = r_in_fill - FILL_W'(1);
    assign w_out_top    = r_out_fill - FILL_W'(1);
    assign w_in_rd_idx  = w_in_top - r_xfer_cnt;
    assign w_out_wr_idx = r_xfer_cnt - FILL_W'(1);
    assign w_in_re      = i_cmd.xfer_rd;
    assign w_out_we     = (i_cmd.xfer_rd && (r_xfer_cnt != '0)) || i_cmd.xfer_fin;

    // Status back to the controller
    assign o_status.full      = (CMP_W'(r_in_fill) >= w_eff_cap);
    assign o_status.in_empty  = (r_in_fill == '0);
    assign o_status.out_empty = (r_out_fill == '0);
    assign o_status.xfer_last = (r_xfer_cnt == w_in_top);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // Total element count, saturated
    assign w_sum   = SUM_W'(r_in_fill) + SUM_W'(r_out_fill);
    assign w_count = (w_sum > SUM_W'(CNT_SAT)) ? CNT_SAT : w_sum[CNT_W-1:0];

    tsfq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DEPTH)
    ) u_in_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq_push),
        .i_waddr (r_in_fill[ADDR_W-1:0]),
        .i_wdata (i_data_in),
        .i_re    (w_in_re),
        .i_raddr (w_in_rd_idx[ADDR_W-1:0]),
        .o_rdata (w_in_rdata)
    );

    tsfq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DEPTH)
    ) u_out_stack (
        .i_clk   (i_clk),
        .i_we    (w_out_we),
        .i_waddr (w_out_wr_idx[ADDR_W-1:0]),
        .i_wdata (w_in_rdata),
        .i_re    (i_cmd.pop_issue),
        .i_raddr (w_out_top[ADDR_W-1:0]),
        .o_rdata (w_out_rdata)
    );

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_wen) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // Fill levels: push, pop, and hand the input stack over on the final move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_fill  <= '0;
            r_out_fill <= '0;
        end else begin
            if (i_cmd.enq_push) begin
                r_in_fill <= r_in_fill + FILL_W'(1);
            end
            if (i_cmd.pop_issue) begin
                r_out_fill <= w_out_top;
            end
            if (i_cmd.xfer_fin) begin
                r_out_fill <= w_in_top;
                r_in_fill  <= '0;
            end
        end
    end

    // Transfer counter: one read issued per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xfer_cnt <= '0;
        end else if (i_cmd.xfer_clr) begin
            r_xfer_cnt <= '0;
        end else if (i_cmd.xfer_rd) begin
            r_xfer_cnt <= r_xfer_cnt + FILL_W'(1);
        end
    end

    // Pending result; the last moved element is the one popped
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_data   <= (i_cmd.res_status == ST_EMPTY) ? {DATA_W{1'b1}} : '0;
        end else if (i_cmd.pop_capture) begin
            r_res_status <= ST_OK;
            r_res_data   <= w_out_rdata;
        end else if (i_cmd.xfer_fin) begin
            r_res_status <= ST_OK;
            r_res_data   <= w_in_rdata;
        end
    end

    // Output register: hold until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_data   <= r_res_data;
            r_out_count  <= w_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;
    assign o_out_count  = r_out_count;

    // Checks
    a_in_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_fill <= FILL_W'(MAX_DEPTH)) && (r_out_fill <= FILL_W'(MAX_DEPTH)))
        else $error("stack fill level beyond depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.enq_push |-> !o_status.full)
        else $error("push into full input stack");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_issue |-> !o_status.out_empty)
        else $error("pop from empty output stack");

    a_fin_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.xfer_fin |-> $past(i_cmd.xfer_rd))
        else $error("transfer finished without a read in flight");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid && (r_out_count == $past(w_count)))
        else $error("result lost at output register");

endmodule

/* src/two_stack_fifo_queue_unit.sv */
// Channel   Direction  Handshake                     Contents
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser command, tdata data_in
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser status, tdata data_out, count
// cfg       in         i_cfg_wen                     i_cfg_wdata capacity
//
// Enqueue and refused dequeue: the result passes the pending-result register, then the output register.
// Dequeue from a non-empty output stack: one output-stack read (S_POP), then S_RESULT.
// Dequeue that moves the input elements: one input-stack read per cycle in S_XFER,
// then S_XFER_FIN and S_RESULT; each element moves once. Commands are accepted only in S_IDLE.
// Reset (synchronous, active low) clears fill levels and sets capacity to 64;
// stack contents are not cleared. One result waits in the output register
// while the next item is accepted; that item then holds until the slot frees.
module two_stack_fifo_queue_unit
    import tsfq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wen,
    input  logic [CAP_W-1:0]          i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [DATA_W-1:0]         s_axis_tdata,   // [31:0] data_in
    input  logic                      s_axis_tuser,   // [0] command
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [DATA_W+CNT_W-1:0]   m_axis_tdata,   // [31:0] data_out, [39:32] count
    output logic [STATUS_W-1:0]       m_axis_tuser    // [1:0] status
);

    t_dp_cmd             w_cmd;
    t_dp_status          w_status;
    logic [STATUS_W-1:0] w_out_status;
    logic [DATA_W-1:0]   w_out_data;
    logic [CNT_W-1:0]    w_out_count;

    tsfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    tsfq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_data_in    (s_axis_tdata),
        .i_cmd        (w_cmd),
        .i_out_ready  (m_axis_tready),
        .o_status     (w_status),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (w_out_status),
        .o_out_data   (w_out_data),
        .o_out_count  (w_out_count)
    );

    // Pack result fields
    assign m_axis_tdata = {w_out_count, w_out_data};
    assign m_axis_tuser = w_out_status;

endmodule

/* dv/two_stack_fifo_queue_unit_tb.sv */
`timescale 1ns / 1ps

module two_stack_fifo_queue_unit_tb;
    import tsfq_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MISMATCH_SHOWN = 10;

    typedef struct {
        t_status            status;
        logic [DATA_W-1:0]  data;
        logic [CNT_W-1:0]   count;
    } t_queue_result;

    // Mirror of the two-stack queue plus the store of expected results
    class fifo_scoreboard;
        logic [DATA_W-1:0]  in_stk [MAX_DEPTH];
        logic [DATA_W-1:0]  out_stk [MAX_DEPTH];
        int                 in_fill = 0;
        int                 out_fill = 0;
        logic [CAP_W-1:0]   capacity = CAP_RESET;
        t_queue_result      expected_results[$];
        int                 errors = 0;
        int                 n_enq = 0;
        int                 n_full = 0;
        int                 n_deq = 0;
        int                 n_empty = 0;
        int                 n_xfer = 0;
        int                 peak_count = 0;

        function int pending();
            return expected_results.size();
        endfunction

        // Apply one accepted command to the mirror and queue its result
        function void apply_command(logic cmd, logic [DATA_W-1:0] data);
            t_queue_result r;
            int eff_cap;
            int total;
            eff_cap = (capacity == 0) ? 1 : ((capacity > MAX_DEPTH) ? MAX_DEPTH : capacity);
            r.status = ST_OK;
            r.data = '0;
            if (cmd == CMD_ENQ) begin
                n_enq++;
                if (in_fill >= eff_cap) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    in_stk[in_fill] = data;
                    in_fill++;
                end
            end else if (in_fill == 0 && out_fill == 0) begin
                n_deq++;
                n_empty++;
                r.status = ST_EMPTY;
                r.data = '1;
            end else begin
                n_deq++;
                // Refill the output stack in reverse, oldest element on top
                if (out_fill == 0) begin
                    n_xfer++;
                    for (int j = 0; j < in_fill; j++)
                        out_stk[j] = in_stk[in_fill - 1 - j];
                    out_fill = in_fill;
                    in_fill = 0;
                end
                out_fill--;
                r.data = out_stk[out_fill];
            end
            total = in_fill + out_fill;
            if (total > peak_count)
                peak_count = total;
            r.count = (total > 255) ? 8'd255 : total[CNT_W-1:0];
            expected_results.push_back(r);
        endfunction

        // Compare one delivered result against the oldest expectation
        function void check_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] data,
                                   logic [CNT_W-1:0] count);
            t_queue_result r;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MISMATCH_SHOWN)
                    $display("ERROR: unexpected result status=%0d data=%08h count=%0d",
                             status, data, count);
                return;
            end
            r = expected_results.pop_front();
            if (status !== r.status || data !== r.data || count !== r.count) begin
                errors++;
                if (errors <= MISMATCH_SHOWN)
                    $display({"ERROR: at %0t expected status=%0d data=%08h count=%0d,",
                              " got status=%0d data=%08h count=%0d"},
                             $realtime, r.status, r.data, r.count, status, data, count);
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wen = 1'b0;
    logic [CAP_W-1:0]           i_cfg_wdata = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [DATA_W-1:0]          s_axis_tdata = '0;      // [31:0] data_in
    logic                       s_axis_tuser = 1'b0;    // [0] command
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [DATA_W+CNT_W-1:0]    m_axis_tdata;           // [31:0] data_out, [39:32] count
    logic [STATUS_W-1:0]        m_axis_tuser;           // [1:0] status

    fifo_scoreboard board = new;
    bit gaps_on = 1'b1;
    int cap_writes = 0;

    two_stack_fifo_queue_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Check each result transaction, then pick the next ready value
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata[DATA_W-1:0],
                               m_axis_tdata[DATA_W +: CNT_W]);
        m_axis_tready <= !(gaps_on && $urandom_range(99) < 31);
    end

    // End the run when no transaction moves for too long
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Present one command and hold it until accepted
    task automatic send_command(input logic cmd, input logic [DATA_W-1:0] data);
        while (gaps_on && $urandom_range(99) < 31) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        board.apply_command(cmd, data);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        board.capacity = value;
        cap_writes++;
    endtask

    // Bias data toward the signed extremes
    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [CAP_W-1:0] phase_caps [8];
        int phase_items [8];
        int phase_enq_pct [8];
        logic cmd;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dequeue, extremes, order across two transfers
        send_command(CMD_DEQ, 32'h1111_1111);
        send_command(CMD_ENQ, 32'h7FFF_FFFF);
        send_command(CMD_ENQ, 32'h8000_0000);
        send_command(CMD_ENQ, 32'hFFFF_FFFF);
        send_command(CMD_ENQ, 32'h0000_0000);
        send_command(CMD_ENQ, 32'h0000_0001);
        send_command(CMD_DEQ, 32'h0);
        send_command(CMD_ENQ, 32'hA5A5_A5A5);
        repeat (5) send_command(CMD_DEQ, $urandom);
        send_command(CMD_DEQ, 32'h0);
        drain();

        // Capacity zero acts as one
        write_capacity(7'd0);
        send_command(CMD_ENQ, 32'h5A5A_5A5A);
        send_command(CMD_ENQ, 32'h3C3C_3C3C);
        send_command(CMD_DEQ, 32'h0);
        send_command(CMD_DEQ, 32'h0);
        drain();

        // Lower the capacity below the fill: refuse enqueue, still move all
        write_capacity(7'd64);
        send_command(CMD_ENQ, 32'hDEAD_0001);
        send_command(CMD_ENQ, 32'hDEAD_0002);
        send_command(CMD_ENQ, 32'hDEAD_0003);
        drain();
        write_capacity(7'd1);
        send_command(CMD_ENQ, 32'hDEAD_0004);
        repeat (3) send_command(CMD_DEQ, 32'h0);
        drain();

        // Random phases, each under its own capacity and enqueue bias
        phase_caps = '{7'd127, 7'd1, 7'd64, CAP_W'($urandom_range(3, 63)), 7'd2, 7'd0,
                       CAP_W'($urandom_range(65, 126)), 7'd64};
        phase_items = '{50, 40, 150, 50, 40, 30, 60, 80};
        phase_enq_pct = '{70, 50, 80, 55, 50, 50, 65, 25};
        for (int p = 0; p < 8; p++) begin
            write_capacity(phase_caps[p]);
            gaps_on = (p != 2);
            for (int i = 0; i < phase_items[p]; i++) begin
                cmd = ($urandom_range(99) < phase_enq_pct[p]) ? CMD_ENQ : CMD_DEQ;
                send_command(cmd, pick_data());
            end
            drain();
        end
        gaps_on = 1'b1;

        $display("Run covered %0d enqueues (%0d refused full), %0d dequeues (%0d on empty)",
                 board.n_enq, board.n_full, board.n_deq, board.n_empty);
        $display("  %0d stack transfers, peak occupancy %0d, %0d capacity writes, %0d mismatches",
                 board.n_xfer, board.peak_count, cap_writes, board.errors);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
src/tsfq_pkg.sv
src/tsfq_ram.sv
src/tsfq_ctrl.sv
src/tsfq_dp.sv
src/two_stack_fifo_queue_unit.sv
dv/two_stack_fifo_queue_unit_tb.sv
